// ===== src/urxf_pkg.sv =====
package urxf_pkg;

    // receive ring geometry
    localparam int RING_DEPTH = 8;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY = 4'd1;

    // reset values of the timing registers
    localparam logic [7:0] BIT_PERIOD_RST  = 8'd32;
    localparam logic [7:0] FIRST_DELAY_RST = 8'd48;

    // received-byte strobe from the deframer
    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } rx_byte_t;

endpackage

// ===== src/urxf_deframer.sv =====
module urxf_deframer import urxf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick_en,
    input  logic       level,
    input  logic [7:0] bit_period,
    input  logic [7:0] first_delay,
    output rx_byte_t   rx_byte
);

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_SAMPLE    = 2'd1,
        PH_WAIT_HIGH = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;

    logic [7:0] target;
    logic [8:0] tick_inc;

    assign target   = (bits_reg == 4'd0) ? first_delay : bit_period;
    assign tick_inc = {1'b0, tick_reg} + 9'd1;

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bits_next    = bits_reg;
        shift_next   = shift_reg;
        rx_byte.done = 1'b0;
        rx_byte.data = shift_reg;
        case (phase_reg)
            PH_SAMPLE: begin
                // a zero target behaves as one since the count is at least one here
                if (tick_inc >= {1'b0, target}) begin
                    tick_next  = 8'd0;
                    shift_next = {level, shift_reg[7:1]};
                    bits_next  = bits_reg + 4'd1;
                    if (bits_reg + 4'd1 >= 4'd8) begin
                        phase_next = PH_WAIT_HIGH;
                    end
                end else begin
                    tick_next = tick_inc[7:0];
                end
            end
            PH_WAIT_HIGH: begin
                // stop bit not checked, just wait for the line to idle high
                if (level) begin
                    rx_byte.done = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (!level) begin
                    phase_next = PH_SAMPLE;
                    tick_next  = 8'd0;
                    bits_next  = 4'd0;
                    shift_next = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 8'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
        end else if (tick_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ===== src/uart_receiver_with_fifo_unit.sv =====
// uart 8n1 receiver with a small receive ring
//
// s_ channel: one transaction per sampling tick of the receive line, carrying
// the line level and a pop request. m_ channel: exactly one result
// transaction per input tick, carrying the popped byte (zero if none), its
// valid flag, the unread count after the tick and a dropped-byte flag.
// cfg channel: writes bit_period (index 0) and first_delay (index 1); it is always ready;
// the user must write it only while the block is idle, and the block does not enforce this.
//
// the tick is worked out in a single pass of logic from the held receiver
// and ring state into the result register.
// throughput is one tick per cycle; a new tick is taken whenever the result
// register is empty or being taken in the same cycle.
// if the receiver of results stalls, s_tready drops and the state holds,
// so no tick is lost. reset clears the deframer to idle, empties the ring
// and restores the timing registers; no clearing pass is needed since ring
// entries are only read after being written.
// a byte finished while the ring holds seven unread bytes is dropped.
module uart_receiver_with_fifo_unit import urxf_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // tick input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] rx_level, [1] pop_req, rest zero
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [7:0] byte_out, [8] byte_valid,
                                              // [11:9] unread_count, [12] overrun
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic       tick_acc;
    logic       rx_level, pop_req;
    rx_byte_t   rx_byte;

    logic [7:0] bit_period_reg;
    logic [7:0] first_delay_reg;

    logic [7:0]       ring_reg [RING_DEPTH];
    logic [PTR_W-1:0] wr_slot_reg, wr_slot_next;
    logic [PTR_W-1:0] rd_slot_reg, rd_slot_next;
    logic [PTR_W-1:0] pop_slot;
    logic             push_ok;
    logic             pop_ok;
    logic [CNT_W-1:0] unread;

    logic       m_valid_reg;
    logic [7:0] byte_out_reg, byte_out_next;
    logic       byte_valid_reg;
    logic [2:0] count_reg;
    logic       overrun_reg;

    assign rx_level = s_tdata[0];
    assign pop_req  = s_tdata[1];

    // output register frees up when its content is taken
    assign s_tready = !m_valid_reg || m_tready;
    assign tick_acc = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    urxf_deframer u_deframer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (tick_acc),
        .level       (rx_level),
        .bit_period  (bit_period_reg),
        .first_delay (first_delay_reg),
        .rx_byte     (rx_byte)
    );

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb begin
        // read slot trails the oldest entry by one, equal slots mean full
        push_ok      = rx_byte.done && (wr_slot_reg != rd_slot_reg);
        wr_slot_next = push_ok ? slot_inc(wr_slot_reg) : wr_slot_reg;

        pop_slot     = slot_inc(rd_slot_reg);
        pop_ok       = pop_req && (pop_slot != wr_slot_next);
        rd_slot_next = pop_ok ? pop_slot : rd_slot_reg;

        // byte pushed this tick may be popped in the same tick
        byte_out_next = 8'd0;
        if (pop_ok) begin
            if (push_ok && (pop_slot == wr_slot_reg)) begin
                byte_out_next = rx_byte.data;
            end else begin
                byte_out_next = ring_reg[pop_slot];
            end
        end

        if (wr_slot_next > rd_slot_next) begin
            unread = {1'b0, wr_slot_next} - {1'b0, rd_slot_next} - CNT_W'(1);
        end else begin
            unread = {1'b0, wr_slot_next} + CNT_W'(RING_DEPTH)
                   - {1'b0, rd_slot_next} - CNT_W'(1);
        end
    end

    // ring contents, no reset needed
    always_ff @(posedge aclk) begin
        if (tick_acc && push_ok) begin
            ring_reg[wr_slot_reg] <= rx_byte.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg     <= '0;
            rd_slot_reg     <= PTR_W'(RING_DEPTH - 1);
            m_valid_reg     <= 1'b0;
            bit_period_reg  <= BIT_PERIOD_RST;
            first_delay_reg <= FIRST_DELAY_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                    REG_FIRST_DELAY: first_delay_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (tick_acc) begin
                wr_slot_reg <= wr_slot_next;
                rd_slot_reg <= rd_slot_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            byte_out_reg   <= byte_out_next;
            byte_valid_reg <= pop_ok;
            count_reg      <= unread[2:0];
            overrun_reg    <= rx_byte.done && !push_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, overrun_reg, count_reg, byte_valid_reg, byte_out_reg};

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a byte is only dropped when the ring is full, one less if the same tick popped
    a_overrun_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |->
        (m_tdata[11:9] == (m_tdata[8] ? 3'(RING_DEPTH - 2) : 3'(RING_DEPTH - 1))))
        else $error("overrun reported with room in the ring");

    // a failed pop carries a zero byte
    a_empty_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
        else $error("non-zero byte without valid flag");

endmodule
